### rtl/core/pipt_pkg.sv
// point in polygon test: shared types, constants and the edge crossing function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W          = 24;
    localparam int INDEX_W          = 6;
    localparam int COUNT_W          = 7;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // query word travelling down the chain
    typedef struct packed {
        logic   valid;
        logic   parity;
        coord_t px;
        coord_t pz;
        coord_t first_x;
        coord_t first_z;
        coord_t prev_x;
        coord_t prev_z;
    } tok_t;

    function automatic logic edge_toggles(input coord_t ax, input coord_t az,
                                          input coord_t bx, input coord_t bz,
                                          input coord_t px, input coord_t pz);
        logic signed [COORD_W:0]     dz;
        logic signed [COORD_W:0]     dpx;
        logic signed [COORD_W:0]     dbx;
        logic signed [COORD_W:0]     dpz;
        logic signed [2*COORD_W+1:0] lhs;
        logic signed [2*COORD_W+1:0] rhs;
        logic                        straddle;
        logic                        hit;
        straddle = ((az > pz) != (bz > pz));
        dz  = (COORD_W+1)'(bz) - (COORD_W+1)'(az);
        dpx = (COORD_W+1)'(px) - (COORD_W+1)'(ax);
        dbx = (COORD_W+1)'(bx) - (COORD_W+1)'(ax);
        dpz = (COORD_W+1)'(pz) - (COORD_W+1)'(az);
        lhs = (2*COORD_W+2)'(dpx) * (2*COORD_W+2)'(dz);
        rhs = (2*COORD_W+2)'(dbx) * (2*COORD_W+2)'(dpz);
        if (dz > 0) begin
            hit = (lhs < rhs);
        end else begin
            hit = (lhs > rhs);
        end
        return straddle && hit;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pipt_cell.sv
// one vertex cell: holds a vertex and folds its edge into the passing query word
// depends on pipt_pkg
`timescale 1ns / 1ps
`default_nettype none

module pipt_cell
    import pipt_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_en,
    input  wire coord_t wr_x,
    input  wire coord_t wr_z,
    input  wire logic   active,
    input  wire tok_t   tok_in,
    output tok_t        tok_out
);

    coord_t vx_reg;
    coord_t vz_reg;
    tok_t   tok_reg;
    tok_t   tok_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vx_reg <= wr_x;
            vz_reg <= wr_z;
        end
    end

    always_comb begin
        tok_next = tok_in;
        if (tok_in.valid && active) begin
            if (IS_FIRST) begin
                tok_next.first_x = vx_reg;
                tok_next.first_z = vz_reg;
            end else begin
                tok_next.parity = tok_in.parity ^ edge_toggles(vx_reg, vz_reg,
                    tok_in.prev_x, tok_in.prev_z, tok_in.px, tok_in.pz);
            end
            tok_next.prev_x = vx_reg;
            tok_next.prev_z = vz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### rtl/core/point_in_polygon_test_top.sv
// point in polygon test top level: vertex cell chain, closing edge and result registers
// depends on pipt_pkg and pipt_cell
//
// usage:
//   input channel s_*: a word with s_func = write stores (s_coord_x, s_coord_z) in slot
//   s_vertex_index (slots at or above MAX_VERTICES are dropped) and gives no result;
//   s_func = query tests (s_coord_x, s_coord_z) against the first vertex_count vertices
//   by the even-odd rule and gives one word on m_* (m_inside_res).
//   config channel cfg_*: cfg_data sets vertex_count; write only while idle.
//   a query walks the row of MAX_VERTICES vertex cells, one cell per cycle, and the
//   closing edge is folded in as the result register loads; the query passes all
//   MAX_VERTICES cells whatever vertex_count is, inactive cells passing it on unchanged.
//   one query is in flight at a time: the next is not accepted until the result of
//   the last has been loaded, and a write is refused only while a query is in flight.
//   a result waiting on m_ready does not block writes or the acceptance of the next
//   query; that query's result then waits in a spare register until the first has been
//   taken, and no further query is accepted while the spare is full.
//   reset empties the chain and the result registers and clears vertex_count to zero;
//   vertex slots are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_top
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [INDEX_W-1:0] s_vertex_index,
    input  wire coord_t             s_coord_x,
    input  wire coord_t             s_coord_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_inside_res,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] count_reg;
    logic               busy_reg;
    logic               busy_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic               inside_reg;
    logic               inside_next;
    logic               spare_valid_reg;
    logic               spare_valid_next;
    logic               spare_inside_reg;
    logic               spare_inside_next;

    logic               s_fire;
    logic               wr_fire;
    logic               query_fire;
    logic               closing;
    logic               query_res;

    tok_t               launch;
    tok_t               chain [MAX_VERTICES+1];
    tok_t               last;

    assign s_ready    = !busy_reg && ((s_func == FUNC_WRITE) || !spare_valid_reg);
    assign s_fire     = s_valid && s_ready;
    assign wr_fire    = s_fire && (s_func == FUNC_WRITE);
    assign query_fire = s_fire && (s_func == FUNC_QUERY);
    assign cfg_ready  = 1'b1;

    always_comb begin
        launch         = '0;
        launch.valid   = query_fire;
        launch.px      = s_coord_x;
        launch.pz      = s_coord_z;
        launch.first_x = s_coord_x;
        launch.first_z = s_coord_z;
        launch.prev_x  = s_coord_x;
        launch.prev_z  = s_coord_z;
    end

    assign chain[0] = launch;

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        logic wr_en;
        logic active;
        assign wr_en  = wr_fire && (32'(s_vertex_index) == 32'(i));
        assign active = (32'(i) < 32'(count_reg));
        pipt_cell #(
            .IS_FIRST(i == 0)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .wr_en  (wr_en),
            .wr_x   (s_coord_x),
            .wr_z   (s_coord_z),
            .active (active),
            .tok_in (chain[i]),
            .tok_out(chain[i+1])
        );
    end

    assign last = chain[MAX_VERTICES];

    // closing edge from vertex 0 back to the last used vertex
    assign closing = (count_reg != '0) && edge_toggles(last.first_x, last.first_z,
        last.prev_x, last.prev_z, last.px, last.pz);

    assign query_res = last.parity ^ closing;

    always_comb begin
        busy_next         = busy_reg;
        m_valid_next      = m_valid_reg;
        inside_next       = inside_reg;
        spare_valid_next  = spare_valid_reg;
        spare_inside_next = spare_inside_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next     = spare_valid_reg;
            inside_next      = spare_inside_reg;
            spare_valid_next = 1'b0;
        end
        if (last.valid) begin
            if (m_valid_next) begin
                spare_valid_next  = 1'b1;
                spare_inside_next = query_res;
            end else begin
                m_valid_next = 1'b1;
                inside_next  = query_res;
            end
            busy_next = 1'b0;
        end
        if (query_fire) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            busy_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            busy_reg        <= busy_next;
            m_valid_reg     <= m_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inside_reg       <= inside_next;
        spare_inside_reg <= spare_inside_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = inside_reg;

endmodule

`default_nettype wire
